@@ design/bbmq_pkg.sv @@
// ----------------------------------------------------------------------------
// bbmq_pkg
// Shared codes and types for the byte budget message queue.
// ----------------------------------------------------------------------------
package bbmq_pkg;

    localparam int CNT_W = 7;   // producer_count and finished total

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_REMOVED   = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd3;
    localparam logic [2:0] ST_CLOSED    = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;
    localparam logic [2:0] ST_BUSY      = 3'd7;

    localparam logic REG_QUEUE_BYTES    = 1'b0;
    localparam logic REG_PRODUCER_COUNT = 1'b1;

    typedef struct packed {
        logic        is_add;
        logic        is_remove;
        logic        is_finish;
        logic        blocking;
        logic [63:0] msg_handle;
        logic [31:0] msg_bytes;
        logic [15:0] receiver;
        logic [5:0]  finisher_id;
    } t_req;

    typedef struct packed {
        logic        op;
        logic [2:0]  status;
        logic [63:0] out_handle;
        logic [31:0] out_bytes;
        logic [15:0] out_receiver;
    } t_res;

    typedef struct packed {
        logic        en;
        logic        idx;
        logic [31:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [31:0]      queue_bytes;
        logic [CNT_W-1:0] producer_count;
    } t_cfg_rd;

endpackage

@@ design/bbmq_if.sv @@
// ----------------------------------------------------------------------------
// bbmq request and response channels
// Valid/ready channels carrying requests in and results out.
// ----------------------------------------------------------------------------
interface bbmq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        blocking;
    logic [63:0] msg_handle;
    logic [31:0] msg_bytes;
    logic [15:0] receiver;
    logic [5:0]  finisher_id;

    modport source (output valid, mode, blocking, msg_handle, msg_bytes, receiver,
                    finisher_id, input ready);
    modport sink   (input valid, mode, blocking, msg_handle, msg_bytes, receiver,
                    finisher_id, output ready);
endinterface

interface bbmq_out_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [2:0]  status;
    logic [63:0] out_handle;
    logic [31:0] out_bytes;
    logic [15:0] out_receiver;
    logic        is_empty;
    logic        drained_closed;
    logic        last;

    modport source (output valid, op, status, out_handle, out_bytes, out_receiver,
                    is_empty, drained_closed, last, input ready);
    modport sink   (input valid, op, status, out_handle, out_bytes, out_receiver,
                    is_empty, drained_closed, last, output ready);
endinterface

@@ design/bbmq_ram.sv @@
// ----------------------------------------------------------------------------
// bbmq_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/bbmq_front.sv @@
// ----------------------------------------------------------------------------
// bbmq_front
// Accepts requests, decodes the mode and queues them for the sequencer.
// ----------------------------------------------------------------------------
module bbmq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bbmq_in_if.sink           i_req,
    output logic              o_req_valid,
    output bbmq_pkg::t_req    o_req,
    input  logic              i_req_take
);
    bbmq_pkg::t_req r_buf [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    bbmq_pkg::t_req w_dec;
    logic           w_push, w_pop;

    always_comb begin
        w_dec.is_add      = (i_req.mode == bbmq_pkg::MODE_ADD);
        w_dec.is_remove   = (i_req.mode == bbmq_pkg::MODE_REMOVE);
        w_dec.is_finish   = (i_req.mode == bbmq_pkg::MODE_FINISH);
        w_dec.blocking    = i_req.blocking;
        w_dec.msg_handle  = i_req.msg_handle;
        w_dec.msg_bytes   = i_req.msg_bytes;
        w_dec.receiver    = i_req.receiver;
        w_dec.finisher_id = i_req.finisher_id;
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_req_take && (r_cnt != 2'd0);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

@@ design/bbmq_back.sv @@
// ----------------------------------------------------------------------------
// bbmq_back
// Sequencer: runs one request, then the held removes and adds, and
// delivers the results of the request and of any held requests it served.
// ----------------------------------------------------------------------------
module bbmq_back #(
    parameter int MAX_ENTRIES   = 64,
    parameter int MAX_PRODUCERS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  bbmq_pkg::t_req    i_req,
    output logic              o_req_take,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bbmq_pkg::t_res    o_out,
    output logic              o_out_empty,
    output logic              o_out_drained,
    output logic              o_out_last,
    input  bbmq_pkg::t_cfg_wr i_cfg,
    output bbmq_pkg::t_cfg_rd o_cfg
);
    localparam int PW = $clog2(MAX_ENTRIES);
    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int DW = 64 + 32 + 16;
    localparam int CW = bbmq_pkg::CNT_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_OWN    = 6'b000010,
        S_SRV_R1 = 6'b000100,
        S_SRV_A  = 6'b001000,
        S_SRV_R2 = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    bbmq_pkg::t_req         r_req, n_req;
    logic [31:0]            r_qbytes, n_qbytes;
    logic [CW-1:0]          r_pcount, n_pcount;
    logic [PW-1:0]          r_head, n_head, r_tail, n_tail;
    logic [EW-1:0]          r_count, n_count;
    logic [31:0]            r_free, n_free;
    logic [MAX_PRODUCERS-1:0] r_map, n_map;
    logic [CW-1:0]          r_total, n_total;
    logic                   r_hadd_v, n_hadd_v, r_hrem_v, n_hrem_v;
    logic [63:0]            r_hadd_h, n_hadd_h;
    logic [31:0]            r_hadd_b, n_hadd_b;
    logic [15:0]            r_hadd_r, n_hadd_r;
    bbmq_pkg::t_res         r_res [2];
    bbmq_pkg::t_res         n_res [2];
    logic [1:0]             r_nres, n_nres;
    logic                   r_oidx, n_oidx;
    logic                   r_settled;

    logic                   w_closed, w_full_cnt, w_own_fits, w_held_fits;
    logic                   w_push, w_pop, w_emit, w_emit_op;
    logic [2:0]             w_emit_st;
    logic [63:0]            w_p_h;
    logic [31:0]            w_p_b;
    logic [15:0]            w_p_r;
    logic [DW-1:0]          w_rdata;
    logic [MAX_PRODUCERS-1:0] w_pid_mask;
    logic                   w_pid_ok;
    logic [32:0]            w_refill;
    logic [31:0]            w_held_bytes;
    bbmq_pkg::t_res         w_new;

    bbmq_ram #(.WIDTH(DW), .DEPTH(MAX_ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_tail),
        .i_wdata ({w_p_h, w_p_b, w_p_r}),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    assign w_closed    = (r_total >= r_pcount);
    assign w_full_cnt  = (r_count >= EW'(MAX_ENTRIES));
    assign w_own_fits  = (r_req.msg_bytes <= r_free) && !w_full_cnt;
    assign w_held_fits = (r_hadd_b <= r_free) && !w_full_cnt;
    assign w_pid_ok    = ({1'b0, r_req.finisher_id} < 7'(MAX_PRODUCERS));
    assign w_pid_mask  = MAX_PRODUCERS'(64'd1 << r_req.finisher_id);
    assign w_refill    = {1'b0, r_free} + {1'b0, w_rdata[47:16]};
    assign w_held_bytes = r_qbytes - r_free;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_qbytes  = r_qbytes;
        n_pcount  = r_pcount;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_free    = r_free;
        n_map     = r_map;
        n_total   = r_total;
        n_hadd_v  = r_hadd_v;
        n_hrem_v  = r_hrem_v;
        n_hadd_h  = r_hadd_h;
        n_hadd_b  = r_hadd_b;
        n_hadd_r  = r_hadd_r;
        n_res     = r_res;
        n_nres    = r_nres;
        n_oidx    = r_oidx;
        o_req_take = 1'b0;
        w_push    = 1'b0;
        w_pop     = 1'b0;
        w_emit    = 1'b0;
        w_emit_op = bbmq_pkg::OP_ADD;
        w_emit_st = bbmq_pkg::ST_ADDED;
        w_p_h     = r_req.msg_handle;
        w_p_b     = r_req.msg_bytes;
        w_p_r     = r_req.receiver;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_req_take = 1'b1;
                    n_req      = i_req;
                    n_nres     = 2'd0;
                    n_oidx     = 1'b0;
                    n_state    = S_OWN;
                end
            end
            S_OWN: begin
                n_state = S_SRV_R1;
                if (r_req.is_add) begin
                    w_emit    = 1'b1;
                    w_emit_op = bbmq_pkg::OP_ADD;
                    if (r_req.msg_bytes > r_qbytes) begin
                        w_emit_st = bbmq_pkg::ST_TOO_LARGE;
                    end else if (r_req.msg_bytes == 32'd0) begin
                        w_emit_st = bbmq_pkg::ST_ZERO_SIZE;
                    end else if (w_closed) begin
                        w_emit_st = bbmq_pkg::ST_CLOSED;
                    end else if (w_own_fits) begin
                        w_push    = 1'b1;
                        w_emit_st = bbmq_pkg::ST_ADDED;
                    end else if (!r_req.blocking) begin
                        w_emit_st = bbmq_pkg::ST_FULL;
                    end else if (r_hadd_v) begin
                        w_emit_st = bbmq_pkg::ST_BUSY;
                    end else begin
                        w_emit   = 1'b0;
                        n_hadd_v = 1'b1;
                        n_hadd_h = r_req.msg_handle;
                        n_hadd_b = r_req.msg_bytes;
                        n_hadd_r = r_req.receiver;
                    end
                end else if (r_req.is_remove) begin
                    w_emit_op = bbmq_pkg::OP_REMOVE;
                    if (r_count != '0) begin
                        // wait for the head entry to come out of the RAM
                        if (r_settled) begin
                            w_pop     = 1'b1;
                            w_emit    = 1'b1;
                            w_emit_st = bbmq_pkg::ST_REMOVED;
                        end else begin
                            n_state = S_OWN;
                        end
                    end else if (!r_req.blocking) begin
                        w_emit    = 1'b1;
                        w_emit_st = bbmq_pkg::ST_EMPTY;
                    end else if (w_closed) begin
                        w_emit    = 1'b1;
                        w_emit_st = bbmq_pkg::ST_CLOSED;
                    end else if (r_hrem_v) begin
                        w_emit    = 1'b1;
                        w_emit_st = bbmq_pkg::ST_BUSY;
                    end else begin
                        n_hrem_v = 1'b1;
                    end
                end else if (r_req.is_finish) begin
                    if (w_pid_ok && ((r_map & w_pid_mask) == '0)) begin
                        n_map   = r_map | w_pid_mask;
                        n_total = r_total + CW'(1);
                    end
                end
            end
            S_SRV_R1, S_SRV_R2: begin
                n_state = (r_state == S_SRV_R1) ? S_SRV_A : S_OUT;
                w_emit_op = bbmq_pkg::OP_REMOVE;
                if (r_hrem_v && (r_nres != 2'd2)) begin
                    if (r_count != '0) begin
                        if (r_settled) begin
                            w_pop     = 1'b1;
                            w_emit    = 1'b1;
                            w_emit_st = bbmq_pkg::ST_REMOVED;
                            n_hrem_v  = 1'b0;
                        end else begin
                            n_state = r_state;
                        end
                    end else if (w_closed) begin
                        w_emit    = 1'b1;
                        w_emit_st = bbmq_pkg::ST_CLOSED;
                        n_hrem_v  = 1'b0;
                    end
                end
            end
            S_SRV_A: begin
                n_state = S_SRV_R2;
                w_p_h   = r_hadd_h;
                w_p_b   = r_hadd_b;
                w_p_r   = r_hadd_r;
                if (r_hadd_v && (r_nres != 2'd2) && w_held_fits) begin
                    w_push    = 1'b1;
                    w_emit    = 1'b1;
                    w_emit_st = bbmq_pkg::ST_ADDED;
                    n_hadd_v  = 1'b0;
                end
            end
            S_OUT: begin
                if (r_nres == 2'd0) begin
                    n_state = S_IDLE;
                end else if (i_out_ready) begin
                    if (o_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_oidx = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_push) begin
            n_tail  = (r_tail == PW'(MAX_ENTRIES - 1)) ? '0 : r_tail + PW'(1);
            n_count = r_count + EW'(1);
            n_free  = r_free - w_p_b;
        end
        if (w_pop) begin
            n_head  = (r_head == PW'(MAX_ENTRIES - 1)) ? '0 : r_head + PW'(1);
            n_count = r_count - EW'(1);
            n_free  = (w_refill > {1'b0, r_qbytes}) ? r_qbytes : w_refill[31:0];
        end

        w_new.op           = w_emit_op;
        w_new.status       = w_emit_st;
        w_new.out_handle   = w_pop ? w_rdata[111:48] : 64'd0;
        w_new.out_bytes    = w_pop ? w_rdata[47:16]  : 32'd0;
        w_new.out_receiver = w_pop ? w_rdata[15:0]   : 16'd0;
        if (w_emit) begin
            n_res[r_nres[0]] = w_new;
            n_nres           = r_nres + 2'd1;
        end

        // the user must write configuration only while idle; the block does not enforce it
        if (i_cfg.en) begin
            if (i_cfg.idx == bbmq_pkg::REG_QUEUE_BYTES) begin
                n_qbytes = i_cfg.data;
                n_free   = (i_cfg.data > w_held_bytes) ? i_cfg.data - w_held_bytes : 32'd0;
            end else begin
                n_pcount = i_cfg.data[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_hadd_h <= n_hadd_h;
        r_hadd_b <= n_hadd_b;
        r_hadd_r <= n_hadd_r;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_qbytes  <= 32'd0;
            r_pcount  <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_free    <= 32'd0;
            r_map     <= '0;
            r_total   <= '0;
            r_hadd_v  <= 1'b0;
            r_hrem_v  <= 1'b0;
            r_nres    <= 2'd0;
            r_oidx    <= 1'b0;
            r_settled <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_qbytes  <= n_qbytes;
            r_pcount  <= n_pcount;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_free    <= n_free;
            r_map     <= n_map;
            r_total   <= n_total;
            r_hadd_v  <= n_hadd_v;
            r_hrem_v  <= n_hrem_v;
            r_nres    <= n_nres;
            r_oidx    <= n_oidx;
            r_settled <= !(w_push || w_pop);
        end
    end

    assign o_out_valid   = (r_state == S_OUT) && (r_nres != 2'd0);
    assign o_out         = r_res[r_oidx];
    assign o_out_empty   = (r_count == '0);
    assign o_out_drained = (r_count == '0) && w_closed;
    assign o_out_last    = ({1'b0, r_oidx} == (r_nres - 2'd1));

    assign o_cfg.queue_bytes    = r_qbytes;
    assign o_cfg.producer_count = r_pcount;
endmodule

@@ design/byte_budget_message_queue_unit.sv @@
// Sequencing: a request passes a take step, then the sequencer steps (own step,
// held remove, held add, held remove), then an output step that gives each result
// in turn, or passes through when it has none; a remove right after a push or pop
// waits for the registered read of the descriptor RAM. The sequencer works on one
// request at a time and takes the next only after its results are out; a two-deep
// request queue takes requests while results wait.  Reset is synchronous: control
// state clears, descriptor RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// byte_budget_message_queue_unit
// Message descriptor FIFO with byte budget admission and held requests.
// ----------------------------------------------------------------------------
module byte_budget_message_queue_unit #(
    parameter int MAX_ENTRIES   = 64,
    parameter int MAX_PRODUCERS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bbmq_in_if.sink     i_req,
    bbmq_out_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic              w_req_valid, w_req_take;
    bbmq_pkg::t_req    w_req;
    bbmq_pkg::t_res    w_out;
    bbmq_pkg::t_cfg_wr w_cfg_wr;
    bbmq_pkg::t_cfg_rd w_cfg_rd;

    assign pready        = 1'b1;
    assign w_cfg_wr.en   = psel && penable && pwrite;
    assign w_cfg_wr.idx  = paddr[2];
    assign w_cfg_wr.data = pwdata;
    assign prdata = (paddr[2] == bbmq_pkg::REG_QUEUE_BYTES) ? w_cfg_rd.queue_bytes
                  : {25'd0, w_cfg_rd.producer_count};

    bbmq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_take  (w_req_take)
    );

    bbmq_back #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_PRODUCERS(MAX_PRODUCERS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (w_req_valid),
        .i_req         (w_req),
        .o_req_take    (w_req_take),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_out         (w_out),
        .o_out_empty   (o_rsp.is_empty),
        .o_out_drained (o_rsp.drained_closed),
        .o_out_last    (o_rsp.last),
        .i_cfg         (w_cfg_wr),
        .o_cfg         (w_cfg_rd)
    );

    assign o_rsp.op           = w_out.op;
    assign o_rsp.status       = w_out.status;
    assign o_rsp.out_handle   = w_out.out_handle;
    assign o_rsp.out_bytes    = w_out.out_bytes;
    assign o_rsp.out_receiver = w_out.out_receiver;
endmodule
